### rtl/kmc_pkg.sv
package kmc_pkg;

  // MIDI message fields
  localparam logic [7:0] NOTE_ON           = 8'h90;
  localparam logic [7:0] NOTE_OFF          = 8'h80;
  localparam logic [6:0] VEL_ON            = 7'd127;
  localparam logic [6:0] VEL_OFF           = 7'd0;
  localparam logic [6:0] NOTE_BASE         = 7'd36;
  localparam logic [5:0] LAST_SOUNDING_KEY = 6'd60;

  // Event kinds
  localparam logic EV_NOTE   = 1'b0;
  localparam logic EV_BUTTON = 1'b1;

  // Result cap per row beat and saturation point of the held-button count
  localparam logic [3:0] MAX_RESULTS = 4'd10;
  localparam logic [3:0] HELD_SAT    = 4'd8;

  // Panel button codes, index row*8+bit
  localparam logic [5:0] BUTTON_CODES [64] = '{
    6'd36, 6'd8,  6'd21, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd42, 6'd2,  6'd19, 6'd32, 6'd0,  6'd0,  6'd24, 6'd0,
    6'd41, 6'd9,  6'd20, 6'd31, 6'd0,  6'd11, 6'd23, 6'd0,
    6'd40, 6'd3,  6'd13, 6'd12, 6'd0,  6'd5,  6'd22, 6'd0,
    6'd46, 6'd39, 6'd16, 6'd6,  6'd0,  6'd10, 6'd7,  6'd0,
    6'd45, 6'd43, 6'd15, 6'd34, 6'd0,  6'd4,  6'd1,  6'd0,
    6'd44, 6'd38, 6'd14, 6'd33, 6'd0,  6'd35, 6'd18, 6'd0,
    6'd47, 6'd37, 6'd0,  6'd0,  6'd25, 6'd0,  6'd17, 6'd0
  };

  typedef struct packed {
    logic       event_kind;
    logic [7:0] midi_status;
    logic [6:0] midi_note;
    logic [6:0] midi_velocity;
    logic [5:0] button_code;
    logic       last_of_run;
  } kmc_result_t;

endpackage

### rtl/kmc_row_if.sv
interface kmc_row_if;
  logic        valid;
  logic        ready;
  logic [2:0]  row_index;
  logic [15:0] row_bits;

  modport source (output valid, output row_index, output row_bits, input ready);
  modport sink   (input valid, input row_index, input row_bits, output ready);
endinterface

### rtl/kmc_event_if.sv
interface kmc_event_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] midi_status;
  logic [6:0] midi_note;
  logic [6:0] midi_velocity;
  logic [5:0] button_code;
  logic       last_of_run;

  modport source (output valid, output event_kind, output midi_status, output midi_note,
                  output midi_velocity, output button_code, output last_of_run,
                  input ready);
  modport sink   (input valid, input event_kind, input midi_status, input midi_note,
                  input midi_velocity, input button_code, input last_of_run,
                  output ready);
endinterface

### rtl/kmc_out_reg.sv
module kmc_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kmc_pkg::kmc_result_t data,
  output logic                free,
  kmc_event_if.source         events
);

  logic                 valid_r;
  kmc_pkg::kmc_result_t data_r;

  // Stage is free when empty or when its beat leaves this cycle
  assign free = !valid_r || events.ready;

  // Hold the beat until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (events.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= data;
    end
  end

  assign events.valid         = valid_r;
  assign events.event_kind    = data_r.event_kind;
  assign events.midi_status   = data_r.midi_status;
  assign events.midi_note     = data_r.midi_note;
  assign events.midi_velocity = data_r.midi_velocity;
  assign events.button_code   = data_r.button_code;
  assign events.last_of_run   = data_r.last_of_run;

endmodule

### rtl/key_matrix_change_to_midi_events_top.sv
// A row beat's first event passes the column check, the held result and the output register.
// A row other than the last runs from accept to ready again through one accept step,
// eight column steps of the shared key-change check and one flush of the held result.
// The last row adds 8 held-button counting steps and 64 button scan steps, or only the
// counting when too many are held; an output stall holds the column, scan and flush steps.
// Synchronous reset clears the key and button frames, the sequencer and the output stage.
module key_matrix_change_to_midi_events_top #(
  parameter int NUM_ROWS         = 8,
  parameter int MAX_HELD_BUTTONS = 2
) (
  input  logic        clk,
  input  logic        rst,
  kmc_row_if.sink     rows,
  kmc_event_if.source events
);

  localparam logic [3:0] NUM_ROWS_W = 4'(NUM_ROWS);
  localparam logic [2:0] LAST_ROW   = 3'(NUM_ROWS - 1);
  localparam logic [3:0] MAX_HELD   = 4'(MAX_HELD_BUTTONS);

  typedef enum logic [2:0] {ST_IDLE, ST_KEYS, ST_COUNT, ST_BTNS, ST_FLUSH} state_t;

  state_t               state;
  logic [2:0]           row_r;
  logic [7:0]           keys_r;
  logic [7:0]           chg_r;
  logic                 last_row_r;
  logic [2:0]           col;
  logic [2:0]           crow;
  logic [5:0]           bidx;
  logic [3:0]           held;
  logic [3:0]           nres;
  logic                 pend_valid;
  kmc_pkg::kmc_result_t pend;
  logic [7:0]           key_frame [8];
  logic [6:0]           cur_btn   [8];
  logic [6:0]           prev_btn  [8];

  logic [7:0]           keys_in;
  logic [6:0]           btns_in;
  logic [2:0]           rd_row;
  logic [6:0]           cur_rd;
  logic [6:0]           prev_rd;
  logic [7:0]           pressed_bits;
  logic [5:0]           key_idx;
  logic [5:0]           code;
  logic [3:0]           held_sum;
  logic [3:0]           held_next;
  logic                 found;
  logic                 blocked;
  logic                 out_free;
  logic                 push;
  kmc_pkg::kmc_result_t cand;
  kmc_pkg::kmc_result_t push_data;

  assign rows.ready = (state == ST_IDLE);
  assign keys_in    = ~rows.row_bits[7:0];
  assign btns_in    = ~rows.row_bits[14:8];

  // Share one read port of the button frames between counting and scanning
  assign rd_row       = (state == ST_COUNT) ? crow : bidx[5:3];
  assign cur_rd       = cur_btn[rd_row];
  assign prev_rd      = prev_btn[rd_row];
  assign pressed_bits = {1'b0, cur_rd} & ~{1'b0, prev_rd};
  assign code         = kmc_pkg::BUTTON_CODES[bidx];
  assign key_idx      = {row_r, col};

  // Saturating held-button count
  assign held_sum  = held + 4'($countones(cur_rd));
  assign held_next = (held_sum > kmc_pkg::HELD_SAT) ? kmc_pkg::HELD_SAT : held_sum;

  // Shared check unit: one column or one button position per step
  always_comb begin
    found = 1'b0;
    cand  = '0;
    case (state)
      ST_KEYS: begin
        found              = chg_r[col] && (key_idx <= kmc_pkg::LAST_SOUNDING_KEY);
        cand.event_kind    = kmc_pkg::EV_NOTE;
        cand.midi_status   = keys_r[col] ? kmc_pkg::NOTE_ON : kmc_pkg::NOTE_OFF;
        cand.midi_note     = kmc_pkg::NOTE_BASE + {1'b0, key_idx};
        cand.midi_velocity = keys_r[col] ? kmc_pkg::VEL_ON : kmc_pkg::VEL_OFF;
      end
      ST_BTNS: begin
        found            = pressed_bits[bidx[2:0]] && (code != 6'd0) &&
                           (nres < kmc_pkg::MAX_RESULTS);
        cand.event_kind  = kmc_pkg::EV_BUTTON;
        cand.button_code = code;
      end
      default: begin
        found = 1'b0;
      end
    endcase
  end

  // Keep one result back so the final one can carry last_of_run
  assign blocked = found && pend_valid && !out_free;
  assign push    = pend_valid && out_free && (found || (state == ST_FLUSH));

  always_comb begin
    push_data             = pend;
    push_data.last_of_run = (state == ST_FLUSH);
  end

  // Sequencer, frames and held result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      col        <= '0;
      crow       <= '0;
      bidx       <= '0;
      held       <= '0;
      nres       <= '0;
      for (int i = 0; i < 8; i++) begin
        key_frame[i] <= '0;
        cur_btn[i]   <= '0;
        prev_btn[i]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (rows.valid && ({1'b0, rows.row_index} < NUM_ROWS_W)) begin
            chg_r                     <= keys_in ^ key_frame[rows.row_index];
            keys_r                    <= keys_in;
            row_r                     <= rows.row_index;
            last_row_r                <= (rows.row_index == LAST_ROW);
            key_frame[rows.row_index] <= keys_in;
            cur_btn[rows.row_index]   <= btns_in;
            col                       <= '0;
            nres                      <= '0;
            state                     <= ST_KEYS;
          end
        end
        ST_KEYS: begin
          if (!blocked) begin
            if (found) begin
              pend       <= cand;
              pend_valid <= 1'b1;
              nres       <= nres + 4'd1;
            end
            if (col == 3'd7) begin
              crow  <= '0;
              held  <= '0;
              state <= last_row_r ? ST_COUNT : ST_FLUSH;
            end else begin
              col <= col + 3'd1;
            end
          end
        end
        ST_COUNT: begin
          held <= held_next;
          if (crow == 3'd7) begin
            bidx <= '0;
            if (held_next <= MAX_HELD) begin
              state <= ST_BTNS;
            end else begin
              prev_btn <= cur_btn;
              state    <= ST_FLUSH;
            end
          end else begin
            crow <= crow + 3'd1;
          end
        end
        ST_BTNS: begin
          if (!blocked) begin
            if (found) begin
              pend       <= cand;
              pend_valid <= 1'b1;
              nres       <= nres + 4'd1;
            end
            if (bidx == 6'd63) begin
              prev_btn <= cur_btn;
              state    <= ST_FLUSH;
            end else begin
              bidx <= bidx + 6'd1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  kmc_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .data   (push_data),
    .free   (out_free),
    .events (events)
  );

  // No result may be left behind once a new row beat can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    rows.ready |-> !pend_valid)
    else $error("held result still pending while accepting a row");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    nres <= kmc_pkg::MAX_RESULTS)
    else $error("more results than the cap for one row");

  a_button_fields: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == kmc_pkg::EV_BUTTON) |->
      (events.midi_status == 8'd0) && (events.button_code != 6'd0))
    else $error("malformed button event");

  a_note_range: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == kmc_pkg::EV_NOTE) |->
      (events.midi_note >= 7'd36) && (events.midi_note <= 7'd96) &&
      (events.button_code == 6'd0))
    else $error("note event out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KEYS) && blocked |=> (col == $past(col)) && (state == ST_KEYS))
    else $error("key scan advanced while output was stalled");

endmodule
